@@ sv/bph_pkg.sv @@
// ----------------------------------------------------------------------------
// bph_pkg
// Shared types, constants and helper functions of the bit pattern histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bph_pkg;

	// Longest pattern that is counted and width of one saturating counter.
	localparam int MAX_PATTERN_LEN = 12;
	localparam int COUNT_WIDTH     = 24;

	// Field widths that the interface fixes.
	localparam int LEN_W = 4;
	localparam int CFG_W = 4;

	// The counter store holds one counter per length and pattern: 2 << MAX_PATTERN_LEN.
	localparam int ADDR_W     = MAX_PATTERN_LEN + 1;
	localparam int STORE_SIZE = 2 << MAX_PATTERN_LEN;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [LEN_W-1:0]       LEN_MAX   = LEN_W'(MAX_PATTERN_LEN);

	// Configuration register indexes.
	localparam logic CFG_MIN_LEN = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	// Request codes.
	localparam logic REQ_BIT  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic                       req_type;
		logic                       bit_value;
		logic [LEN_W-1:0]           query_length;
		logic [MAX_PATTERN_LEN-1:0] query_pattern;
	} bph_in_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] pattern_count;
		logic                   query_ok;
	} bph_out_t;

	// One cycle's access to the counter store.
	typedef struct packed {
		logic                   we;
		logic [ADDR_W-1:0]      waddr;
		logic [COUNT_WIDTH-1:0] wdata;
		logic                   re;
		logic [ADDR_W-1:0]      raddr;
	} bph_ram_req_t;

	// Store index of the low len bits of pat: (1 << len) + pattern.
	function automatic logic [ADDR_W-1:0] pat_addr(input logic [LEN_W-1:0] len,
			input logic [MAX_PATTERN_LEN-1:0] pat);
		logic [ADDR_W-1:0] lead;
		lead = ADDR_W'(1) << len;
		return lead | ({1'b0, pat} & (lead - ADDR_W'(1)));
	endfunction

	// Saturating increment of one counter.
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] cnt);
		return (cnt == COUNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
	endfunction

endpackage

`default_nettype wire

@@ sv/bph_count_ram.sv @@
// ----------------------------------------------------------------------------
// bph_count_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bph_count_ram #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/bph_ctrl.sv @@
// ----------------------------------------------------------------------------
// bph_ctrl
// Sequencer of the bit pattern histogram: clears the counter store after
// reset, walks the counted lengths of each stream bit as read-modify-write
// steps and serves count reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bph_ctrl import bph_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire bph_in_t                req,
	output logic                        done,
	output bph_out_t                    result,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	output bph_ram_req_t                ram_req,
	input  wire logic [COUNT_WIDTH-1:0] ram_rdata
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_QUERY
	} state_t;

	state_t                     state_q;
	logic [CFG_W-1:0]           min_q;
	logic [CFG_W-1:0]           max_q;
	logic [MAX_PATTERN_LEN-1:0] hist_q;
	logic [LEN_W-1:0]           seen_q;
	logic [LEN_W-1:0]           len_q;
	logic [LEN_W-1:0]           last_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [ADDR_W-1:0]          addr_s1;
	logic                       ok_s1;

	logic                       accept;
	logic [LEN_W-1:0]           lo;
	logic [LEN_W-1:0]           hi;
	logic [MAX_PATTERN_LEN-1:0] hist_nxt;
	logic [LEN_W-1:0]           seen_nxt;
	logic [LEN_W-1:0]           last_nxt;
	logic [LEN_W-1:0]           len_nxt;
	logic                       any_len;
	logic                       more;
	logic                       query_ok;
	logic [ADDR_W-1:0]          stream_addr;
	logic [ADDR_W-1:0]          query_addr;
	logic [ADDR_W-1:0]          next_addr;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Effective length range and the state a stream bit leaves behind.
	always_comb begin
		lo       = (min_q == '0) ? LEN_W'(1) : min_q;
		hi       = (max_q > LEN_MAX) ? LEN_MAX : max_q;
		hist_nxt = {hist_q[MAX_PATTERN_LEN-2:0], req.bit_value};
		seen_nxt = (seen_q < LEN_MAX) ? seen_q + LEN_W'(1) : seen_q;
		last_nxt = (hi < seen_nxt) ? hi : seen_nxt;
		any_len  = (lo <= last_nxt);
		len_nxt  = len_q + LEN_W'(1);
		more     = (len_q != last_q);
	end

	// Query check and store addresses.
	always_comb begin
		query_ok = (req.query_length >= lo) && (req.query_length <= hi)
			&& (req.query_length != '0) && (req.query_length <= LEN_MAX)
			&& ((req.query_pattern >> req.query_length) == '0);
		stream_addr = pat_addr(lo, hist_nxt);
		query_addr  = pat_addr(req.query_length, req.query_pattern);
		next_addr   = pat_addr(len_nxt, hist_q);
	end

	// Store access of this cycle.
	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
			end
			ST_IDLE: begin
				if (accept && req.req_type == REQ_BIT && any_len) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = stream_addr;
				end else if (accept && req.req_type == REQ_READ && query_ok) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = query_addr;
				end
			end
			ST_UPDATE: begin
				// Write back the counter read last cycle, read the next length.
				ram_req.we    = 1'b1;
				ram_req.waddr = addr_s1;
				ram_req.wdata = sat_inc(ram_rdata);
				ram_req.re    = more;
				ram_req.raddr = next_addr;
			end
			default: begin
			end
		endcase
	end

	// Result beat of a count read.
	always_comb begin
		done                 = (state_q == ST_QUERY);
		result.query_ok      = ok_s1;
		result.pattern_count = ok_s1 ? ram_rdata : '0;
	end

	// State and sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			min_q   <= CFG_W'(1);
			max_q   <= CFG_W'(MAX_PATTERN_LEN);
			hist_q  <= '0;
			seen_q  <= '0;
			len_q   <= '0;
			last_q  <= '0;
			clr_q   <= '0;
			addr_s1 <= '0;
			ok_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_LEN: min_q <= cfg_data;
					CFG_MAX_LEN: max_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(STORE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req.req_type == REQ_BIT) begin
						hist_q  <= hist_nxt;
						seen_q  <= seen_nxt;
						len_q   <= lo;
						last_q  <= last_nxt;
						addr_s1 <= stream_addr;
						if (any_len) begin
							state_q <= ST_UPDATE;
						end
					end else if (accept) begin
						ok_s1   <= query_ok;
						state_q <= ST_QUERY;
					end
				end
				ST_UPDATE: begin
					if (more) begin
						len_q   <= len_nxt;
						addr_s1 <= next_addr;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_QUERY: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/bit_pattern_histogram.sv @@
// ----------------------------------------------------------------------------
// bit_pattern_histogram
// Sliding-window n-gram histogram of a serial bit stream, with saturating
// counters kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   A stream bit (req_type 0) shifts into the history and bumps the counter
//   of every counted length whose window is full; it gives no result. A read
//   (req_type 1) returns the count for query_length and query_pattern, with
//   query_ok low and a zero count when the query is out of range.
//   The result beat sits on result for exactly one cycle, marked by done, in
//   the cycle right after the read is taken; the receiver cannot hold it off.
//   A stream bit keeps busy high while the lengths counted for it (0 to 12)
//   are worked through, since each length is a read then a write through
//   the single RAM port pair, pipelined one length per cycle; the next beat
//   is taken once busy is low. A read keeps busy high during its result beat.
//   Reset: min_len 1, max_len 12, history empty. After reset a clearing pass
//   writes zero to all 8192 counters, one per cycle, with busy high;
//   configuration writes are taken at any time through cfg_we.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bit_pattern_histogram import bph_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bph_in_t          req,
	output logic                  done,
	output bph_out_t              result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	bph_ram_req_t           ram_req;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	// Sequencer.
	bph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// Counter store.
	bph_count_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (COUNT_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

@@ sv/bph_checker.sv @@
// ----------------------------------------------------------------------------
// bph_port_checks
// Port-level checks of the bit pattern histogram, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bph_port_checks import bph_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire bph_in_t          req,
	input wire logic             done,
	input wire bph_out_t         result,
	input wire logic             cfg_we,
	input wire logic             cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);

	// A taken read gives its result beat in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_READ |=> done)
	else $error("read beat gave no result");

	// A taken stream bit is not followed by a result beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_BIT |=> !done)
	else $error("stream bit gave a result");

	// A result beat lasts one cycle.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
	else $error("result beat repeated");

	// No new request is taken while a result is shown.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
	else $error("request taken during result beat");

	// A rejected query reports a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.query_ok |-> result.pattern_count == '0)
	else $error("rejected query with nonzero count");

endmodule

bind bit_pattern_histogram bph_port_checks u_bph_port_checks (.*);

`default_nettype wire

@@ tb/bph_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bph_checker
// Watches the request, result and configuration channels of the bit pattern
// histogram, keeps its own copy of the history and the counters, and checks
// every result beat against the count it predicts for the matching read.
// ----------------------------------------------------------------------------

module bph_checker import bph_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  wire bph_in_t          req,
	input  wire logic             done,
	input  wire bph_out_t         result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    reads_pending
);

	// Shadow of the range registers, the stream history and the counter store.
	logic [CFG_W-1:0]           shadow_min;
	logic [CFG_W-1:0]           shadow_max;
	logic [MAX_PATTERN_LEN-1:0] history;
	int                         filled;
	logic [COUNT_WIDTH-1:0]     tally [STORE_SIZE];

	// Predicted results of reads taken but not yet answered, oldest first.
	bph_out_t                   awaited_reads [$];
	bph_out_t                   oldest;
	int                         error_count;

	// A zero minimum still starts counting at length one.
	function automatic int shortest_counted();
		return (shadow_min == '0) ? 1 : int'(shadow_min);
	endfunction

	// A maximum beyond the history is clipped to the history length.
	function automatic int longest_counted();
		return (int'(shadow_max) > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(shadow_max);
	endfunction

	// Shift a stream bit in and bump every counted length whose window is full.
	task automatic count_bit(input logic b);
		int lo;
		int hi;
		int len;
		int slot;
		lo = shortest_counted();
		hi = longest_counted();
		history = {history[MAX_PATTERN_LEN-2:0], b};
		if (filled < MAX_PATTERN_LEN) begin
			filled++;
		end
		for (len = lo; len <= hi && len <= filled; len++) begin
			slot = (1 << len) + int'(history & ((1 << len) - 1));
			if (tally[slot] != COUNT_MAX) begin
				tally[slot] = tally[slot] + COUNT_WIDTH'(1);
			end
		end
	endtask

	// Count and validity flag that a read should return right now.
	function automatic bph_out_t predict_read(input bph_in_t r);
		bph_out_t answer;
		int       qlen;
		logic     fits;
		qlen = int'(r.query_length);
		fits = qlen >= shortest_counted() && qlen <= longest_counted() && qlen >= 1
			&& qlen <= MAX_PATTERN_LEN && (int'(r.query_pattern) >> qlen) == 0;
		answer.query_ok      = fits;
		answer.pattern_count = fits ? tally[(1 << qlen) + int'(r.query_pattern)] : '0;
		return answer;
	endfunction

	// Track the block beat by beat and compare each result with the oldest read.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_min = CFG_W'(1);
			shadow_max = CFG_W'(MAX_PATTERN_LEN);
			history    = '0;
			filled     = 0;
			for (int i = 0; i < STORE_SIZE; i++) begin
				tally[i] = '0;
			end
			awaited_reads.delete();
			error_count = 0;
			mismatches    <= 0;
			reads_pending <= 0;
		end else begin
			if (done) begin
				if (awaited_reads.size() == 0) begin
					if (error_count < 10) begin
						$display("%0t: result beat with no read waiting: count %0d ok %0b",
							$realtime, result.pattern_count, result.query_ok);
					end
					error_count++;
				end else begin
					oldest = awaited_reads.pop_front();
					if (result.pattern_count !== oldest.pattern_count
							|| result.query_ok !== oldest.query_ok) begin
						if (error_count < 10) begin
							$display("%0t: expected count %0d ok %0b, got count %0d ok %0b",
								$realtime, oldest.pattern_count, oldest.query_ok,
								result.pattern_count, result.query_ok);
						end
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				if (req.req_type == REQ_BIT) begin
					count_bit(req.bit_value);
				end else begin
					awaited_reads.insert(awaited_reads.size(), predict_read(req));
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_LEN) begin
					shadow_min = cfg_data;
				end else begin
					shadow_max = cfg_data;
				end
			end
			mismatches    <= error_count;
			reads_pending <= awaited_reads.size();
		end
	end

endmodule

@@ tb/bit_pattern_histogram_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_pattern_histogram_test
// Drives stream bits and count reads into the bit pattern histogram under a
// series of counting ranges, with random gaps between beats, and leaves the
// checking to bph_checker; gives the verdict once every read is answered.
// ----------------------------------------------------------------------------

module bit_pattern_histogram_test;
	import bph_pkg::*;

	localparam int STALL_LIMIT     = 40000;
	localparam int ITEMS_PER_PHASE = 158;
	localparam int SETTLE_CYCLES   = 16;

	// Counting ranges of the fixed phases, element zero last.
	localparam logic [5:0][CFG_W-1:0] PHASE_MIN = {4'd15, 4'd3, 4'd1, 4'd12, 4'd5, 4'd0};
	localparam logic [5:0][CFG_W-1:0] PHASE_MAX = {4'd0, 4'd8, 4'd1, 4'd12, 4'd3, 4'd15};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	bph_in_t          req       = '0;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = CFG_MIN_LEN;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	bph_out_t         result;
	int               mismatches;
	int               reads_pending;

	// Stimulus side view of the range and of the last bits sent.
	logic [CFG_W-1:0]           cur_min   = CFG_W'(1);
	logic [CFG_W-1:0]           cur_max   = CFG_W'(MAX_PATTERN_LEN);
	logic [MAX_PATTERN_LEN-1:0] sent_bits = '0;
	logic                       steady    = 1'b0;
	int                         stall_cycles = 0;

	bit_pattern_histogram uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bph_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.reads_pending (reads_pending)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Present one beat and hold it until the block takes it.
	task automatic send_beat(input bph_in_t beat);
		int gap;
		start <= 1'b1;
		req   <= beat;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A stream bit; the unused query fields carry noise.
	task automatic send_bit(input logic b);
		bph_in_t beat;
		beat.req_type      = REQ_BIT;
		beat.bit_value     = b;
		beat.query_length  = LEN_W'($urandom_range(0, 15));
		beat.query_pattern = MAX_PATTERN_LEN'($urandom_range(0, 4095));
		sent_bits = {sent_bits[MAX_PATTERN_LEN-2:0], b};
		send_beat(beat);
	endtask

	// A count read; the unused stream bit carries noise.
	task automatic send_read(input int len, input int pat);
		bph_in_t beat;
		beat.req_type      = REQ_READ;
		beat.bit_value     = 1'($urandom_range(0, 1));
		beat.query_length  = LEN_W'(len);
		beat.query_pattern = MAX_PATTERN_LEN'(pat);
		send_beat(beat);
	endtask

	// Mostly stream bits, else mostly well-formed reads in the counted range, often of a recent pattern.
	task automatic send_random_beat();
		int                         pick;
		int                         lo;
		int                         hi;
		int                         len;
		logic [MAX_PATTERN_LEN-1:0] mask;
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			send_bit(1'($urandom_range(0, 1)));
		end else if (pick < 88) begin
			lo = (cur_min == '0) ? 1 : int'(cur_min);
			hi = (int'(cur_max) > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(cur_max);
			if (lo > hi) begin
				lo = 1;
				hi = MAX_PATTERN_LEN;
			end
			len  = $urandom_range(hi, lo);
			mask = MAX_PATTERN_LEN'((1 << len) - 1);
			if ($urandom_range(0, 1) == 1) begin
				send_read(len, int'(sent_bits & mask));
			end else begin
				send_read(len, int'(MAX_PATTERN_LEN'($urandom_range(0, 4095)) & mask));
			end
		end else begin
			send_read($urandom_range(0, 15), $urandom_range(0, 4095));
		end
	endtask

	// Wait until every read is answered and the counter updates are done.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (reads_pending != 0 || busy) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Set a new counting range while the block is idle.
	task automatic set_range(input int lo, input int hi);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_LEN;
		cfg_data  <= CFG_W'(lo);
		@(posedge clk);
		cfg_index <= CFG_MAX_LEN;
		cfg_data  <= CFG_W'(hi);
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_min = CFG_W'(lo);
		cur_max = CFG_W'(hi);
	endtask

	initial begin
		int phase;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reads before any bit, then bad lengths at both ends.
		send_read(1, 0);
		send_read(0, 0);
		send_read(13, 0);
		send_read(15, 4095);
		// Fill the history with ones and read back all-ones patterns and the absent pattern 10.
		repeat (12) send_bit(1'b1);
		send_read(12, 4095);
		send_read(1, 1);
		send_read(2, 2);
		// Pattern with a bit above its length.
		send_read(3, 8);
		send_bit(1'b0);
		send_read(12, 4094);
		send_read(4, 0);

		// Random phases under the fixed ranges first, then random ranges.
		for (phase = 0; phase < 9; phase++) begin
			if (phase < 6) begin
				set_range(int'(PHASE_MIN[phase]), int'(PHASE_MAX[phase]));
			end else begin
				set_range($urandom_range(0, 15), $urandom_range(0, 15));
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0) begin
					steady = ($urandom_range(0, 3) == 0);
				end
				send_random_beat();
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/bph_pkg.sv
sv/bph_count_ram.sv
sv/bph_ctrl.sv
sv/bit_pattern_histogram.sv
sv/bph_checker.sv
tb/bph_checker.sv
tb/bit_pattern_histogram_test.sv
